// ===== src/lrm_pkg.sv =====
package lrm_pkg;

    localparam int NUM_SOURCES = 8;
    localparam int SRC_BITS    = 3;
    localparam int KEY_BITS    = 64;
    localparam int VALUE_BITS  = 64;

    // input kinds
    localparam logic [1:0] KIND_ENTRY     = 2'd0;
    localparam logic [1:0] KIND_EXHAUSTED = 2'd1;
    localparam logic [1:0] KIND_START     = 2'd2;

    // result kinds
    localparam logic [1:0] OUT_RECORD = 2'd0;
    localparam logic [1:0] OUT_FETCH  = 2'd1;
    localparam logic [1:0] OUT_FINISH = 2'd2;

    // register indexes
    localparam logic [1:0] REG_LOW_KEY     = 2'd0;
    localparam logic [1:0] REG_END_KEY     = 2'd1;
    localparam logic [1:0] REG_END_ENABLED = 2'd2;
    localparam logic [1:0] REG_SCAN_LIMIT  = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SELECT,
        ST_MIN,
        ST_DECIDE,
        ST_RECORD,
        ST_FETCH,
        ST_FINISH
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic take_in;      // register the accepted item
        logic start_scan;   // clear heads and counters
        logic apply_in;     // install head or mark exhausted
        logic consume;      // drop heads matching the winner, count record
        logic finish;       // set scan finished
        logic load_fetch;   // seed fetch scan mask
        logic fetch_all;    // fetch mask is all sources
        logic fetch_one;    // fetch mask is the input source only
        logic fetch_step;   // clear lowest fetch bit
    } ctrl_t;

    // datapath to controller
    typedef struct packed {
        logic [1:0] kind;
        logic       relevant;     // entry or exhaust notice that counts
        logic       below_start;  // entry below the lower bound
        logic       waiting;      // some live source without a head
        logic       limit_hit;    // limit reached before selection
        logic       none_valid;   // no head at all
        logic       past_end;     // winner at or beyond end_key
        logic       emit;         // winner is not a tombstone
        logic       limit_after;  // limit reached after this record
        logic       fetch_any;    // a fetch remains
        logic       fetch_final;  // current fetch is the last one
    } stat_t;

endpackage

// ===== src/lrm_datapath.sv =====
module lrm_datapath (
    input  logic                           clk,
    input  logic                           rst_n,
    input  lrm_pkg::ctrl_t                 ctrl,
    output lrm_pkg::stat_t                 stat,
    input  logic                           cfg_we,
    input  logic [1:0]                     cfg_index,
    input  logic [63:0]                    cfg_data,
    input  logic [1:0]                     in_kind,
    input  logic [lrm_pkg::SRC_BITS-1:0]   in_source,
    input  logic [lrm_pkg::KEY_BITS-1:0]   in_key,
    input  logic [lrm_pkg::VALUE_BITS-1:0] in_value,
    input  logic                           in_deleted,
    output logic [lrm_pkg::SRC_BITS-1:0]   win_source,
    output logic [lrm_pkg::KEY_BITS-1:0]   win_key,
    output logic [lrm_pkg::VALUE_BITS-1:0] win_value,
    output logic [lrm_pkg::SRC_BITS-1:0]   fetch_source
);

    localparam int N = lrm_pkg::NUM_SOURCES;

    logic [63:0] low_key_reg, end_key_reg;
    logic        end_enabled_reg;
    logic [31:0] scan_limit_reg;

    logic [N-1:0] head_valid_reg, head_valid_next;
    logic [N-1:0] exhausted_reg, exhausted_next;
    logic [lrm_pkg::KEY_BITS-1:0]   head_key_reg [N];
    logic [lrm_pkg::VALUE_BITS-1:0] head_value_reg [N];
    logic [N-1:0] head_tomb_reg;
    logic [31:0]  yielded_reg;
    logic         finished_reg;

    logic [1:0]                     kind_reg;
    logic [lrm_pkg::SRC_BITS-1:0]   src_reg;
    logic [lrm_pkg::KEY_BITS-1:0]   key_reg;
    logic [lrm_pkg::VALUE_BITS-1:0] value_reg;
    logic                           del_reg;

    logic [lrm_pkg::SRC_BITS-1:0]   win_reg;
    logic                           win_any_reg;
    logic [N-1:0]                   fetch_reg;

    // config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_key_reg     <= '0;
            end_key_reg     <= '0;
            end_enabled_reg <= 1'b0;
            scan_limit_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                lrm_pkg::REG_LOW_KEY:     low_key_reg     <= cfg_data;
                lrm_pkg::REG_END_KEY:     end_key_reg     <= cfg_data;
                lrm_pkg::REG_END_ENABLED: end_enabled_reg <= cfg_data[0];
                lrm_pkg::REG_SCAN_LIMIT:  scan_limit_reg  <= cfg_data[31:0];
                default: ;
            endcase
        end
    end

    // hold the accepted item
    always_ff @(posedge clk)
    begin
        if (ctrl.take_in)
        begin
            kind_reg  <= in_kind;
            src_reg   <= in_source;
            key_reg   <= in_key;
            value_reg <= in_value;
            del_reg   <= in_deleted;
        end
    end

    logic src_ok;
    assign src_ok = (32'(src_reg) < 32'(N));

    // minimum select over heads as a pairwise tree, lower index wins ties
    logic [lrm_pkg::KEY_BITS-1:0] tree_key [2*N];
    logic [lrm_pkg::SRC_BITS-1:0] tree_idx [2*N];
    logic [2*N-1:0]               tree_valid;
    logic [lrm_pkg::SRC_BITS-1:0] min_idx;
    logic                         min_any;
    always_comb
    begin
        tree_key[0]   = '0;
        tree_idx[0]   = '0;
        tree_valid[0] = 1'b0;
        for (int i = 0; i < N; i++)
        begin
            tree_key[N + i]   = head_key_reg[i];
            tree_idx[N + i]   = lrm_pkg::SRC_BITS'(i);
            tree_valid[N + i] = head_valid_reg[i];
        end
        for (int j = N - 1; j >= 1; j--)
        begin
            if (tree_valid[2*j+1]
                && (!tree_valid[2*j] || tree_key[2*j+1] < tree_key[2*j]))
            begin
                tree_key[j] = tree_key[2*j+1];
                tree_idx[j] = tree_idx[2*j+1];
            end
            else
            begin
                tree_key[j] = tree_key[2*j];
                tree_idx[j] = tree_idx[2*j];
            end
            tree_valid[j] = tree_valid[2*j] | tree_valid[2*j+1];
        end
        min_idx = tree_idx[1];
        min_any = tree_valid[1];
    end

    always_ff @(posedge clk)
    begin
        win_reg     <= min_idx;
        win_any_reg <= min_any;
    end

    logic [31:0] yielded_inc;
    assign yielded_inc = yielded_reg + 32'd1;

    // status towards the controller
    always_comb
    begin
        stat.kind        = kind_reg;
        stat.relevant    = !finished_reg && src_ok && !head_valid_reg[src_reg]
                           && !exhausted_reg[src_reg]
                           && (kind_reg == lrm_pkg::KIND_ENTRY
                               || kind_reg == lrm_pkg::KIND_EXHAUSTED);
        stat.below_start = (kind_reg == lrm_pkg::KIND_ENTRY)
                           && (key_reg < low_key_reg[lrm_pkg::KEY_BITS-1:0]);
        stat.waiting     = |(~head_valid_reg & ~exhausted_reg);
        stat.limit_hit   = (scan_limit_reg != 0) && (yielded_reg >= scan_limit_reg);
        stat.none_valid  = !win_any_reg;
        stat.past_end    = end_enabled_reg
                           && (64'(head_key_reg[win_reg]) >= end_key_reg);
        stat.emit        = !head_tomb_reg[win_reg];
        stat.limit_after = (scan_limit_reg != 0) && (yielded_inc >= scan_limit_reg);
        stat.fetch_any   = |fetch_reg;
        stat.fetch_final = ((fetch_reg & (fetch_reg - N'(1))) == '0);
    end

    // lowest pending fetch
    always_comb
    begin
        fetch_source = '0;
        for (int i = N - 1; i >= 0; i--)
        begin
            if (fetch_reg[i])
            begin
                fetch_source = lrm_pkg::SRC_BITS'(i);
            end
        end
    end

    assign win_source = win_reg;
    assign win_key    = head_key_reg[win_reg];
    assign win_value  = head_value_reg[win_reg];

    // head state update
    always_comb
    begin
        head_valid_next = head_valid_reg;
        exhausted_next  = exhausted_reg;
        if (ctrl.start_scan)
        begin
            head_valid_next = '0;
            exhausted_next  = '0;
        end
        else if (ctrl.apply_in)
        begin
            if (kind_reg == lrm_pkg::KIND_EXHAUSTED)
            begin
                exhausted_next[src_reg] = 1'b1;
            end
            else
            begin
                head_valid_next[src_reg] = 1'b1;
            end
        end
        else if (ctrl.consume)
        begin
            for (int i = 0; i < N; i++)
            begin
                if (head_valid_reg[i] && head_key_reg[i] == head_key_reg[win_reg])
                begin
                    head_valid_next[i] = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= '0;
            exhausted_reg  <= '0;
            yielded_reg    <= '0;
            finished_reg   <= 1'b1;
            fetch_reg      <= '0;
        end
        else
        begin
            head_valid_reg <= head_valid_next;
            exhausted_reg  <= exhausted_next;
            if (ctrl.start_scan)
            begin
                yielded_reg  <= '0;
                finished_reg <= 1'b0;
            end
            else if (ctrl.consume && stat.emit)
            begin
                yielded_reg <= yielded_inc;
            end
            if (ctrl.finish)
            begin
                finished_reg <= 1'b1;
            end
            if (ctrl.load_fetch)
            begin
                if (ctrl.fetch_all)
                begin
                    fetch_reg <= '1;
                end
                else if (ctrl.fetch_one)
                begin
                    fetch_reg <= N'(1) << src_reg;
                end
                else
                begin
                    fetch_reg <= ~head_valid_next & ~exhausted_next;
                end
            end
            else if (ctrl.fetch_step)
            begin
                fetch_reg <= fetch_reg & (fetch_reg - N'(1));
            end
        end
    end

    // head payload storage
    always_ff @(posedge clk)
    begin
        if (ctrl.apply_in && kind_reg == lrm_pkg::KIND_ENTRY)
        begin
            head_key_reg[src_reg]   <= key_reg;
            head_value_reg[src_reg] <= value_reg;
            head_tomb_reg[src_reg]  <= del_reg;
        end
    end

endmodule

// ===== src/lrm_control.sv =====
module lrm_control (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [1:0]     out_kind,
    output logic           out_last,
    output logic           out_from_fetch,
    output lrm_pkg::ctrl_t ctrl,
    input  lrm_pkg::stat_t stat
);

    lrm_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lrm_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        ctrl           = '0;
        in_ready       = 1'b0;
        out_valid      = 1'b0;
        out_kind       = lrm_pkg::OUT_RECORD;
        out_last       = 1'b0;
        out_from_fetch = 1'b0;
        unique case (state_reg)
            lrm_pkg::ST_IDLE:
            begin
                in_ready     = 1'b1;
                ctrl.take_in = in_valid;
                if (in_valid)
                begin
                    state_next = lrm_pkg::ST_SELECT;
                end
            end
            // act on the held item
            lrm_pkg::ST_SELECT:
            begin
                if (stat.kind == lrm_pkg::KIND_START)
                begin
                    ctrl.start_scan = 1'b1;
                    ctrl.load_fetch = 1'b1;
                    ctrl.fetch_all  = 1'b1;
                    state_next      = lrm_pkg::ST_FETCH;
                end
                else if (!stat.relevant)
                begin
                    state_next = lrm_pkg::ST_IDLE;
                end
                else if (stat.below_start)
                begin
                    ctrl.load_fetch = 1'b1;
                    ctrl.fetch_one  = 1'b1;
                    state_next      = lrm_pkg::ST_FETCH;
                end
                else
                begin
                    ctrl.apply_in = 1'b1;
                    state_next    = lrm_pkg::ST_MIN;
                end
            end
            // heads updated; let the minimum select register its winner
            lrm_pkg::ST_MIN:
            begin
                state_next = lrm_pkg::ST_DECIDE;
            end
            // winner registered; check stop conditions
            lrm_pkg::ST_DECIDE:
            begin
                priority if (stat.waiting)
                begin
                    state_next = lrm_pkg::ST_IDLE;
                end
                else if (stat.limit_hit || stat.none_valid || stat.past_end)
                begin
                    ctrl.finish = 1'b1;
                    state_next  = lrm_pkg::ST_FINISH;
                end
                else if (stat.emit)
                begin
                    state_next = lrm_pkg::ST_RECORD;
                end
                else
                begin
                    ctrl.consume    = 1'b1;
                    ctrl.load_fetch = 1'b1;
                    state_next      = lrm_pkg::ST_FETCH;
                end
            end
            lrm_pkg::ST_RECORD:
            begin
                out_valid = 1'b1;
                out_kind  = lrm_pkg::OUT_RECORD;
                if (out_ready)
                begin
                    ctrl.consume = 1'b1;
                    if (stat.limit_after)
                    begin
                        ctrl.finish = 1'b1;
                        state_next  = lrm_pkg::ST_FINISH;
                    end
                    else
                    begin
                        ctrl.load_fetch = 1'b1;
                        state_next      = lrm_pkg::ST_FETCH;
                    end
                end
            end
            // one fetch per source still lacking a head
            lrm_pkg::ST_FETCH:
            begin
                if (!stat.fetch_any)
                begin
                    state_next = lrm_pkg::ST_IDLE;
                end
                else
                begin
                    out_valid      = 1'b1;
                    out_kind       = lrm_pkg::OUT_FETCH;
                    out_from_fetch = 1'b1;
                    out_last       = stat.fetch_final;
                    if (out_ready)
                    begin
                        ctrl.fetch_step = 1'b1;
                        if (stat.fetch_final)
                        begin
                            state_next = lrm_pkg::ST_IDLE;
                        end
                    end
                end
            end
            lrm_pkg::ST_FINISH:
            begin
                out_valid = 1'b1;
                out_kind  = lrm_pkg::OUT_FINISH;
                out_last  = 1'b1;
                if (out_ready)
                begin
                    state_next = lrm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lrm_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== src/lsm_range_merge.sv =====
// lsm_range_merge: k-way merge of sorted sources into one range scan.
// Input items arrive on s_axis_* (kind in tuser: entry, exhausted, start);
// results leave on m_axis_* (records, fetch requests, scan finished), with
// tlast on the final result caused by each input item.
// Configure the lower bound key, end_key, end_enabled and scan_limit through
// cfg_we/cfg_index/cfg_data while no scan item is being processed.
// A start item answers with one fetch per source. Each entry either asks
// for the same source again (below the lower bound) or becomes that source's
// head; once every live source has a head the smallest key is taken, then
// a record (unless tombstone) then fetches or a finish, or only a finish.
// A start item or a refused entry goes through ST_SELECT before its first
// result; an entry or exhausted notice that updates the heads goes through
// the head update (ST_SELECT), the registered minimum select (ST_MIN) and
// the decision (ST_DECIDE) first. Results then follow back to back while
// m_axis_tready is high. An item causing no result frees the input from
// ST_SELECT (ignored) or ST_DECIDE (still waiting for a source).
// The block takes one item at a time; s_axis_tready is high only when idle.
// When m_axis_tready is low the pending result is held steady.
// Reset clears all heads and marks the scan finished; configuration
// registers return to zero.
module lsm_range_merge (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [63:0]  cfg_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // tdata: source[2:0], key[66:3], value[130:67], deleted[131], zero pad
    input  logic [135:0] s_axis_tdata,
    // tuser: kind[1:0]
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // tdata: out_source[2:0], out_key[66:3], out_value[130:67], zero pad
    output logic [135:0] m_axis_tdata,
    // tuser: out_kind[1:0]
    output logic [1:0]   m_axis_tuser,
    output logic         m_axis_tlast
);

    lrm_pkg::ctrl_t ctrl;
    lrm_pkg::stat_t stat;
    logic [1:0] out_kind;
    logic       from_fetch;
    logic [lrm_pkg::SRC_BITS-1:0]   win_source, fetch_source;
    logic [lrm_pkg::KEY_BITS-1:0]   win_key;
    logic [lrm_pkg::VALUE_BITS-1:0] win_value;

    lrm_control u_control (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s_axis_tvalid),
        .in_ready      (s_axis_tready),
        .out_valid     (m_axis_tvalid),
        .out_ready     (m_axis_tready),
        .out_kind      (out_kind),
        .out_last      (m_axis_tlast),
        .out_from_fetch(from_fetch),
        .ctrl          (ctrl),
        .stat          (stat)
    );

    lrm_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .stat        (stat),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_kind     (s_axis_tuser),
        .in_source   (s_axis_tdata[2:0]),
        .in_key      (s_axis_tdata[66:3]),
        .in_value    (s_axis_tdata[130:67]),
        .in_deleted  (s_axis_tdata[131]),
        .win_source  (win_source),
        .win_key     (win_key),
        .win_value   (win_value),
        .fetch_source(fetch_source)
    );

    // build the result item
    always_comb
    begin
        m_axis_tuser = out_kind;
        m_axis_tdata = '0;
        if (from_fetch)
        begin
            m_axis_tdata[2:0] = fetch_source;
        end
        else if (out_kind == lrm_pkg::OUT_RECORD)
        begin
            m_axis_tdata[2:0]    = win_source;
            m_axis_tdata[66:3]   = win_key;
            m_axis_tdata[130:67] = win_value;
        end
    end

endmodule

// ===== tb/sv/testbench.sv =====
module testbench;

    typedef struct {
        logic [1:0]  kind;
        logic [2:0]  src;
        logic [63:0] key;
        logic [63:0] value;
        logic        last;
    } merge_res_t;

    logic         clk;
    logic         rst_n;
    logic         cfg_we;
    logic [1:0]   cfg_index;
    logic [63:0]  cfg_data;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [135:0] s_axis_tdata;
    logic [1:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [135:0] m_axis_tdata;
    logic [1:0]   m_axis_tuser;
    logic         m_axis_tlast;

    // predicted merge results, oldest first
    merge_res_t   merge_q[$];
    int           errors;
    int           items_sent;
    bit           no_idle;
    int           rx_stall;

    // predictor copy of configuration and scan state
    logic [63:0]  cfg_low_key;
    logic [63:0]  cfg_end_key;
    logic         cfg_end_on;
    logic [31:0]  cfg_limit;
    logic         hd_valid [lrm_pkg::NUM_SOURCES];
    logic [63:0]  hd_key [lrm_pkg::NUM_SOURCES];
    logic [63:0]  hd_value [lrm_pkg::NUM_SOURCES];
    logic         hd_tomb [lrm_pkg::NUM_SOURCES];
    logic         src_done [lrm_pkg::NUM_SOURCES];
    logic [31:0]  emitted;
    logic         scan_idle;

    // per-source entry streams that the scan driver offers
    logic [63:0]  feed_key [lrm_pkg::NUM_SOURCES][$];
    logic [63:0]  feed_val [lrm_pkg::NUM_SOURCES][$];
    logic         feed_del [lrm_pkg::NUM_SOURCES][$];

    lsm_range_merge u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #3000000;
        $display("** lsm_range_merge: FAILED **");
        $finish;
    end

    task automatic report(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        errors++;
    endtask

    function automatic void add_res(logic [1:0] k, logic [2:0] s, logic [63:0] key,
                                    logic [63:0] val);
        merge_res_t r;
        r.kind = k; r.src = s; r.key = key; r.value = val; r.last = 1'b0;
        merge_q.insert(merge_q.size(), r);
    endfunction

    function automatic void end_scan();
        scan_idle = 1'b1;
        add_res(lrm_pkg::OUT_FINISH, 3'd0, 64'd0, 64'd0);
    endfunction

    // pick the smallest head once no live source is waiting
    function automatic void select_min();
        int win;
        logic [63:0] k;
        logic emit;
        win = -1;
        for (int i = 0; i < lrm_pkg::NUM_SOURCES; i++)
            if (!hd_valid[i] && !src_done[i])
                return;
        if (cfg_limit != 0 && emitted >= cfg_limit)
        begin
            end_scan();
            return;
        end
        for (int i = 0; i < lrm_pkg::NUM_SOURCES; i++)
            if (hd_valid[i] && (win < 0 || hd_key[i] < hd_key[win]))
                win = i;
        if (win < 0 || (cfg_end_on && hd_key[win] >= cfg_end_key))
        begin
            end_scan();
            return;
        end
        k = hd_key[win];
        emit = !hd_tomb[win];
        if (emit)
        begin
            add_res(lrm_pkg::OUT_RECORD, win[2:0], k, hd_value[win]);
            emitted++;
        end
        for (int i = 0; i < lrm_pkg::NUM_SOURCES; i++)
            if (hd_valid[i] && hd_key[i] == k)
                hd_valid[i] = 1'b0;
        if (emit && cfg_limit != 0 && emitted >= cfg_limit)
        begin
            end_scan();
            return;
        end
        for (int i = 0; i < lrm_pkg::NUM_SOURCES; i++)
            if (!hd_valid[i] && !src_done[i])
                add_res(lrm_pkg::OUT_FETCH, i[2:0], 64'd0, 64'd0);
    endfunction

    function automatic void predict_merge(logic [1:0] kind, logic [2:0] src,
                                          logic [63:0] key, logic [63:0] val, logic del);
        int n0;
        n0 = merge_q.size();
        if (kind == lrm_pkg::KIND_START)
        begin
            for (int i = 0; i < lrm_pkg::NUM_SOURCES; i++)
            begin
                hd_valid[i] = 1'b0;
                src_done[i] = 1'b0;
                add_res(lrm_pkg::OUT_FETCH, i[2:0], 64'd0, 64'd0);
            end
            emitted = 0;
            scan_idle = 1'b0;
        end
        else if ((kind == lrm_pkg::KIND_ENTRY || kind == lrm_pkg::KIND_EXHAUSTED)
                 && !scan_idle && !hd_valid[src] && !src_done[src])
        begin
            if (kind == lrm_pkg::KIND_EXHAUSTED)
            begin
                src_done[src] = 1'b1;
                select_min();
            end
            else if (key < cfg_low_key)
                add_res(lrm_pkg::OUT_FETCH, src, 64'd0, 64'd0);
            else
            begin
                hd_valid[src] = 1'b1;
                hd_key[src] = key;
                hd_value[src] = val;
                hd_tomb[src] = del;
                select_min();
            end
        end
        if (merge_q.size() > n0)
            merge_q[$].last = 1'b1;
    endfunction

    // send one item and predict its results once it is accepted
    task automatic send_item(input logic [1:0] kind, input logic [2:0] src,
                             input logic [63:0] key, input logic [63:0] val,
                             input logic del);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {4'd0, del, val, key, src};
        do
            @(posedge clk);
        while (!s_axis_tready);
        predict_merge(kind, src, key, val, del);
        items_sent++;
    endtask

    // write a register once the block has drained
    task automatic write_reg(input logic [1:0] idx, input logic [63:0] data);
        s_axis_tvalid <= 1'b0;
        while (merge_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            lrm_pkg::REG_LOW_KEY:     cfg_low_key = data;
            lrm_pkg::REG_END_KEY:     cfg_end_key = data;
            lrm_pkg::REG_END_ENABLED: cfg_end_on = data[0];
            default:                  cfg_limit = data[31:0];
        endcase
    endtask

    task automatic set_range(input logic [63:0] lo, input logic [63:0] hi,
                             input logic hi_on, input logic [31:0] lim);
        write_reg(lrm_pkg::REG_LOW_KEY, lo);
        write_reg(lrm_pkg::REG_END_KEY, hi);
        write_reg(lrm_pkg::REG_END_ENABLED, {63'd0, hi_on});
        write_reg(lrm_pkg::REG_SCAN_LIMIT, {32'd0, lim});
    endtask

    function automatic void feed(int s, logic [63:0] k, logic [63:0] v, logic d);
        feed_key[s].insert(feed_key[s].size(), k);
        feed_val[s].insert(feed_val[s].size(), v);
        feed_del[s].insert(feed_del[s].size(), d);
    endfunction

    // start a scan and answer fetches from the feed streams; noise_pct adds junk
    task automatic run_scan(input int noise_pct);
        int pend[$];
        int s;
        int steps;
        send_item(lrm_pkg::KIND_START, 3'd0, 64'd0, 64'd0, 1'b0);
        steps = 0;
        while (!scan_idle && steps < 200)
        begin
            steps++;
            if ($urandom_range(1, 100) <= noise_pct)
            begin
                send_item($urandom_range(0, 3) == 0 ? 2'd3 : 2'($urandom_range(0, 1)),
                          3'($urandom_range(0, 7)), {$urandom, $urandom},
                          {$urandom, $urandom}, 1'($urandom_range(0, 1)));
                continue;
            end
            pend.delete();
            for (int i = 0; i < lrm_pkg::NUM_SOURCES; i++)
                if (!hd_valid[i] && !src_done[i])
                    pend.insert(pend.size(), i);
            if (pend.size() == 0)
                break;
            s = pend[$urandom_range(0, pend.size() - 1)];
            if (feed_key[s].size() == 0)
                send_item(lrm_pkg::KIND_EXHAUSTED, s[2:0], 64'd0, 64'd0, 1'b0);
            else
                send_item(lrm_pkg::KIND_ENTRY, s[2:0], feed_key[s].pop_front(),
                          feed_val[s].pop_front(), feed_del[s].pop_front());
        end
        for (int i = 0; i < lrm_pkg::NUM_SOURCES; i++)
        begin
            feed_key[i].delete();
            feed_val[i].delete();
            feed_del[i].delete();
        end
    endtask

    task automatic test_ties_and_tombstones();
        set_range(64'd0, 64'd0, 1'b0, 32'd0);
        feed(0, 64'd5, 64'hAAAA, 1'b0);
        feed(3, 64'd5, 64'hBBBB, 1'b0);
        feed(3, 64'd9, 64'hCCCC, 1'b1);
        feed(5, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        feed(7, 64'd0, 64'd0, 1'b0);
        run_scan(0);
    endtask

    task automatic test_range_bounds();
        set_range(64'd10, 64'd20, 1'b1, 32'd0);
        feed(1, 64'd3, 64'd1, 1'b0);
        feed(1, 64'd12, 64'd2, 1'b0);
        feed(2, 64'd15, 64'd3, 1'b0);
        feed(2, 64'd20, 64'd4, 1'b0);
        run_scan(0);
    endtask

    task automatic test_limit();
        set_range(64'd0, 64'd0, 1'b0, 32'd2);
        for (int i = 0; i < lrm_pkg::NUM_SOURCES; i++)
            feed(i, 64'(i), 64'(i * 7), 1'b0);
        run_scan(0);
    endtask

    // idle items, unsolicited entries, unknown kind and restart
    task automatic test_ignored_items();
        set_range(64'd0, 64'd0, 1'b0, 32'hFFFF_FFFF);
        send_item(lrm_pkg::KIND_ENTRY, 3'd2, 64'd1, 64'd1, 1'b0);
        send_item(lrm_pkg::KIND_EXHAUSTED, 3'd4, 64'd0, 64'd0, 1'b0);
        send_item(lrm_pkg::KIND_START, 3'd0, 64'd0, 64'd0, 1'b0);
        send_item(lrm_pkg::KIND_ENTRY, 3'd6, 64'd8, 64'd2, 1'b0);
        send_item(lrm_pkg::KIND_ENTRY, 3'd6, 64'd9, 64'd3, 1'b0);
        send_item(lrm_pkg::KIND_EXHAUSTED, 3'd6, 64'd0, 64'd0, 1'b0);
        send_item(2'd3, 3'd1, 64'd0, 64'd0, 1'b0);
        send_item(lrm_pkg::KIND_EXHAUSTED, 3'd1, 64'd0, 64'd0, 1'b0);
        send_item(lrm_pkg::KIND_ENTRY, 3'd1, 64'd4, 64'd4, 1'b0);
        send_item(lrm_pkg::KIND_START, 3'd0, 64'd0, 64'd0, 1'b0);
        run_scan(0);
    endtask

    task automatic test_random_scans();
        logic [63:0] base;
        logic [63:0] k;
        int n;
        while (items_sent < 120)
        begin
            base = {$urandom, $urandom} >> $urandom_range(0, 63);
            case ($urandom_range(0, 3))
                0: set_range(64'd0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 32'd0);
                1: set_range(base + 4, base + $urandom_range(8, 40), 1'b1, 32'd0);
                2: set_range(base, base + 30, 1'($urandom_range(0, 1)),
                             $urandom_range(1, 6));
                default: set_range({$urandom, $urandom}, {$urandom, $urandom},
                                   1'($urandom_range(0, 1)), 32'hFFFF_FFFF);
            endcase
            no_idle = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < lrm_pkg::NUM_SOURCES; i++)
            begin
                n = $urandom_range(0, 4);
                k = base;
                for (int j = 0; j < n; j++)
                begin
                    k = k + $urandom_range(0, 5);
                    feed(i, k, {$urandom, $urandom}, $urandom_range(0, 4) == 0);
                end
            end
            run_scan($urandom_range(0, 1) ? 0 : 10);
            no_idle = 1'b0;
        end
    endtask

    // receiver: random stalls per result, then compare with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (merge_q.size() == 0)
                report("result with no prediction");
            else
            begin
                if (m_axis_tuser != merge_q[0].kind)
                    report($sformatf("kind %0d exp %0d", m_axis_tuser, merge_q[0].kind));
                if (m_axis_tdata[2:0] != merge_q[0].src)
                    report($sformatf("source %0d exp %0d", m_axis_tdata[2:0],
                                     merge_q[0].src));
                if (m_axis_tdata[66:3] != merge_q[0].key)
                    report($sformatf("key %h exp %h", m_axis_tdata[66:3], merge_q[0].key));
                if (m_axis_tdata[130:67] != merge_q[0].value)
                    report($sformatf("value %h exp %h", m_axis_tdata[130:67],
                                     merge_q[0].value));
                if (m_axis_tlast != merge_q[0].last)
                    report($sformatf("last %0d exp %0d", m_axis_tlast, merge_q[0].last));
                void'(merge_q.pop_front());
            end
            rx_stall = no_idle ? 0 : $urandom_range(0, 10);
        end
        m_axis_tready <= (rx_stall == 0);
        if (rx_stall > 0)
            rx_stall--;
    end

    initial
    begin
        errors        = 0;
        items_sent    = 0;
        no_idle       = 1'b0;
        rx_stall      = 0;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = lrm_pkg::REG_LOW_KEY;
        cfg_data      = 64'd0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = lrm_pkg::KIND_ENTRY;
        m_axis_tready = 1'b0;
        cfg_low_key   = 64'd0;
        cfg_end_key   = 64'd0;
        cfg_end_on    = 1'b0;
        cfg_limit     = 32'd0;
        emitted       = 32'd0;
        scan_idle     = 1'b1;
        for (int i = 0; i < lrm_pkg::NUM_SOURCES; i++)
        begin
            hd_valid[i] = 1'b0;
            src_done[i] = 1'b0;
        end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_ties_and_tombstones();
        test_range_bounds();
        test_limit();
        test_ignored_items();
        test_random_scans();

        @(posedge clk);
        s_axis_tvalid <= 1'b0;
        while (merge_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("** lsm_range_merge: PASSED **");
        else
            $display("** lsm_range_merge: FAILED **");
        $finish;
    end
endmodule

// ===== filelist.f =====
src/lrm_pkg.sv
src/lrm_datapath.sv
src/lrm_control.sv
src/lsm_range_merge.sv
tb/sv/testbench.sv
